[rtl/periodic_timer_bank_macros.svh]
// ----------------------------------------------------------------------------
// periodic_timer_bank_macros
// assertion macros for the checker file of the timer bank
// ----------------------------------------------------------------------------
`ifndef PERIODIC_TIMER_BANK_MACROS_SVH
`define PERIODIC_TIMER_BANK_MACROS_SVH

// property checked on every clock edge outside reset
`define PTB_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property that also holds across reset
`define PTB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/ptb_pkg.sv]
// ----------------------------------------------------------------------------
// ptb_pkg
// shared constants, command and result types, state encodings of the timer bank
// ----------------------------------------------------------------------------
package ptb_pkg;

  // bank geometry
  localparam int NUM_TIMERS  = 16;
  localparam int SLICE_MS    = 10;
  localparam int MAX_RESULTS = 16;
  localparam int TIDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int RES_IDX_W   = 4;
  localparam int RC_W        = $clog2(MAX_RESULTS + 1);

  // ms to slice: multiply by ceil(2^(32+SLICE_SHIFT) / SLICE_MS), keep the top
  // bits; exact for every 32-bit input since the rounding error stays below
  // 2^SLICE_SHIFT
  localparam int          SLICE_SHIFT = $clog2(SLICE_MS);
  localparam logic [32:0] SLICE_RECIP =
    33'(((64'd1 << (32 + SLICE_SHIFT)) + 64'(SLICE_MS - 1)) / 64'(SLICE_MS));

  // queues
  localparam int CMDQ_DEPTH = 2;
  localparam int CQ_AW      = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int CQ_CW      = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 2 * MAX_RESULTS;
  localparam int RQ_AW      = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
  localparam int RQ_CW      = $clog2(RESQ_DEPTH + 1);

  // item kinds on the input channel
  localparam logic [1:0] KIND_TICK  = 2'd0;
  localparam logic [1:0] KIND_DELAY = 2'd1;
  localparam logic [1:0] KIND_LOAD  = 2'd2;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_DELAY,
    OP_LOAD
  } op_t;

  // classified command, front to back
  // a: tick slice / now slice / first firing slice
  // b: delay slice (never zero) / loaded period
  typedef struct packed {
    op_t               op;
    logic [TIDX_W-1:0] idx;
    logic [31:0]       a;
    logic [31:0]       b;
    logic              restart;
    logic              first_en;
    logic              act;
  } cmd_t;

  // one timer entry in the timer memory
  typedef struct packed {
    logic [31:0] period;
    logic [31:0] last;
    logic [31:0] saved;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic                 fired;
    logic [RES_IDX_W-1:0] idx;
    logic                 last;
  } result_t;

  localparam result_t RES_NOFIRE = '{fired: 1'b0, idx: '0, last: 1'b1};

  typedef enum logic [1:0] {
    F_IDLE,
    F_DIV,
    F_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DELAY,
    B_WALK,
    B_DONE
  } back_state_t;

endpackage

[rtl/ptb_in_if.sv]
// ----------------------------------------------------------------------------
// ptb_in_if
// input item channel of the timer bank: valid, ready and the item fields
// ----------------------------------------------------------------------------
interface ptb_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [31:0] now_ms;
  logic [3:0]  timer_index;
  logic [31:0] fire_delay_ms;
  logic        restart_from_now;
  logic [31:0] period_slices;
  logic [31:0] first_at_slice;
  logic        first_enable;
  logic        active;

  modport source (
    output valid, kind, now_ms, timer_index, fire_delay_ms, restart_from_now,
           period_slices, first_at_slice, first_enable, active,
    input  ready
  );

  modport sink (
    input  valid, kind, now_ms, timer_index, fire_delay_ms, restart_from_now,
           period_slices, first_at_slice, first_enable, active,
    output ready
  );
endinterface

[rtl/ptb_out_if.sv]
// ----------------------------------------------------------------------------
// ptb_out_if
// result channel of the timer bank: valid, ready and the result fields
// ----------------------------------------------------------------------------
interface ptb_out_if;
  logic       valid;
  logic       ready;
  logic       fired;
  logic [3:0] fired_index;
  logic       last_of_run;

  modport source (
    output valid, fired, fired_index, last_of_run,
    input  ready
  );

  modport sink (
    input  valid, fired, fired_index, last_of_run,
    output ready
  );
endinterface

[rtl/periodic_timer_bank.sv]
// Bank of NUM_TIMERS periodic timers counted in slices of SLICE_MS ms. Every
// input transaction (tick, set delay or load) produces one or more result
// transactions; the final one of each item carries last_of_run. A tick whose
// slice equals the previous tick's slice, a set delay, a load, an unused kind
// or an out-of-range index produce a single non-firing result. On a new tick
// slice the timers are checked in index order and each expired timer yields
// one result (at most MAX_RESULTS are reported, all expired timers update).
// Flow: the front turns now_ms and fire_delay_ms into slices with a
// reciprocal multiply in state F_DIV, so a tick or in-range set delay passes
// through F_IDLE, F_DIV and F_PUSH, and other items skip F_DIV. The back walks
// the timer memory one entry per cycle, so a tick passes through B_IDLE,
// B_WALK and B_DONE, a set delay through B_IDLE and B_DELAY, and a load is
// done in B_IDLE. The two halves overlap through a two-entry command queue,
// so the timer walk sets the sustained tick rate. The back starts an item
// only when the result queue has MAX_RESULTS free entries, so a stalled
// result consumer eventually holds off input. Timer entries never written
// read as zero; no clearing pass is needed after reset.
// ----------------------------------------------------------------------------
// periodic_timer_bank
// top level: front (divide and classify), command queue, back (timer walk)
// ----------------------------------------------------------------------------
module periodic_timer_bank (
  input  logic      clk,
  input  logic      rst,
  ptb_in_if.sink    items,
  ptb_out_if.source results
);
  import ptb_pkg::*;

  // front to queue
  cmd_t front_cmd;
  logic front_valid;
  logic front_ready;

  // queue to back
  cmd_t back_cmd;
  logic back_valid;
  logic back_ready;

  // front: takes a transaction, converts ms to slices, drops repeated tick
  // slices and out-of-range indexes to a no-op command
  ptb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .items     (items),
    .cmd       (front_cmd),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready)
  );

  // decoupling queue, lets the front prepare the next item while the back walks
  ptb_cmdq u_cmdq (
    .clk        (clk),
    .rst        (rst),
    .push_data  (front_cmd),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_data   (back_cmd),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  // back: owns the timer memory, the active and first-shot flags, and the
  // result queue that drives the output channel
  ptb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd       (back_cmd),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .results   (results)
  );

endmodule

[rtl/ptb_ram.sv]
// ----------------------------------------------------------------------------
// ptb_ram
// generic single-write, single-read memory with registered read data
// ----------------------------------------------------------------------------
module ptb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/ptb_front.sv]
// ----------------------------------------------------------------------------
// ptb_front
// accepts items, turns milliseconds into slices and classifies each item
// ----------------------------------------------------------------------------
module ptb_front (
  input  logic          clk,
  input  logic          rst,
  ptb_in_if.sink        items,
  output ptb_pkg::cmd_t cmd,
  output logic          cmd_valid,
  input  logic          cmd_ready
);
  import ptb_pkg::*;

  // ms to slice by reciprocal multiply
  function automatic logic [31:0] to_slice(input logic [31:0] ms);
    logic [64:0] prod;
    prod = {33'd0, ms} * {32'd0, SLICE_RECIP};
    return 32'(prod >> (32 + SLICE_SHIFT));
  endfunction

  front_state_t      state, state_next;
  op_t               op_q;
  logic [TIDX_W-1:0] idx_q;
  logic              restart_q;
  logic              fe_q;
  logic              act_q;
  logic [31:0]       x0, x1;
  logic [31:0]       prev_slice;
  logic              accept;
  logic              idx_ok;
  op_t               op_new;

  assign items.ready = (state == F_IDLE);
  assign accept      = items.valid && items.ready;
  assign idx_ok      = ({28'd0, items.timer_index} < 32'(NUM_TIMERS));

  always_comb begin
    unique case (items.kind)
      KIND_TICK:  op_new = OP_TICK;
      KIND_DELAY: op_new = idx_ok ? OP_DELAY : OP_NOP;
      KIND_LOAD:  op_new = idx_ok ? OP_LOAD : OP_NOP;
      default:    op_new = OP_NOP;
    endcase
  end

  always_comb begin
    state_next = state;
    cmd_valid  = 1'b0;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (op_new == OP_TICK || op_new == OP_DELAY) begin
            state_next = F_DIV;
          end else begin
            state_next = F_PUSH;
          end
        end
      end
      F_DIV: begin
        state_next = F_PUSH;
      end
      F_PUSH: begin
        cmd_valid = 1'b1;
        if (cmd_ready) begin
          state_next = F_IDLE;
        end
      end
      default: state_next = F_IDLE;
    endcase
  end

  // a tick in the slice of the previous tick does nothing; zero delay means one slice
  always_comb begin
    cmd          = '0;
    cmd.op       = op_q;
    cmd.idx      = idx_q;
    cmd.a        = x0;
    cmd.b        = x1;
    cmd.restart  = restart_q;
    cmd.first_en = fe_q;
    cmd.act      = act_q;
    if (op_q == OP_TICK && x0 == prev_slice) begin
      cmd.op = OP_NOP;
    end
    if (op_q == OP_DELAY && x1 == '0) begin
      cmd.b = 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= F_IDLE;
      prev_slice <= '0;
    end else begin
      state <= state_next;
      if (cmd_valid && cmd_ready && cmd.op == OP_TICK) begin
        prev_slice <= x0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= op_new;
      idx_q     <= TIDX_W'(items.timer_index);
      restart_q <= items.restart_from_now;
      fe_q      <= items.first_enable;
      act_q     <= items.active;
      if (items.kind == KIND_LOAD) begin
        x0 <= items.first_enable ? items.first_at_slice : '0;
        x1 <= items.period_slices;
      end else begin
        x0 <= items.now_ms;
        x1 <= items.fire_delay_ms;
      end
    end else if (state == F_DIV) begin
      x0 <= to_slice(x0);
      x1 <= to_slice(x1);
    end
  end

endmodule

[rtl/ptb_cmdq.sv]
// ----------------------------------------------------------------------------
// ptb_cmdq
// short command queue between the front and the back of the timer bank
// ----------------------------------------------------------------------------
module ptb_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  ptb_pkg::cmd_t push_data,
  input  logic          push_valid,
  output logic          push_ready,
  output ptb_pkg::cmd_t pop_data,
  output logic          pop_valid,
  input  logic          pop_ready
);
  import ptb_pkg::*;

  cmd_t             q [CMDQ_DEPTH];
  logic [CQ_AW-1:0] wr_ptr, rd_ptr;
  logic [CQ_CW-1:0] cnt;
  logic             push, pop;

  assign push_ready = (cnt != CQ_CW'(CMDQ_DEPTH));
  assign pop_valid  = (cnt != '0);
  assign pop_data   = q[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CQ_AW'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

[rtl/ptb_back.sv]
// ----------------------------------------------------------------------------
// ptb_back
// executes commands on the timer memory, walks the timers on a tick and
// queues the results
// ----------------------------------------------------------------------------
module ptb_back (
  input  logic          clk,
  input  logic          rst,
  input  ptb_pkg::cmd_t cmd,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  ptb_out_if.source     results
);
  import ptb_pkg::*;

  back_state_t       state, state_next;
  cmd_t              cur;
  logic [TIDX_W-1:0] walk_idx, walk_idx_next;
  logic              hold_vld, hold_vld_next;
  logic [TIDX_W-1:0] hold_idx, hold_idx_next;
  logic [RC_W-1:0]   rep_cnt, rep_cnt_next;

  logic [NUM_TIMERS-1:0] ent_valid;
  logic [NUM_TIMERS-1:0] active_r;
  logic [NUM_TIMERS-1:0] fpend_r;
  logic                  rd_ok;

  logic               ram_we;
  logic [TIDX_W-1:0]  ram_waddr, ram_raddr;
  entry_t             ram_wdata;
  logic [ENTRY_W-1:0] ram_rdata;
  entry_t             ev;

  logic              load_wr;
  logic              fp_clr;
  logic [31:0]       ref_slice, limit;
  logic              fire;
  logic              space_ok;

  result_t          rq [RESQ_DEPTH];
  logic [RQ_AW-1:0] rq_wr, rq_rd;
  logic [RQ_CW-1:0] rq_cnt;
  logic             rq_push, rq_pop;
  result_t          rq_din;

  ptb_ram #(.WIDTH(ENTRY_W), .DEPTH(NUM_TIMERS)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // never-written entries read as zero
  assign ev = rd_ok ? entry_t'(ram_rdata) : '0;

  // first shot measures from slice zero to the stored absolute slice
  assign ref_slice = fpend_r[walk_idx] ? 32'd0 : ev.last;
  assign limit     = fpend_r[walk_idx] ? ev.last : ev.period;
  assign fire      = active_r[walk_idx] && ((cur.a - ref_slice) >= limit);
  assign space_ok  = (rq_cnt <= RQ_CW'(RESQ_DEPTH - MAX_RESULTS));

  always_comb begin
    state_next    = state;
    cmd_ready     = 1'b0;
    walk_idx_next = walk_idx;
    hold_vld_next = hold_vld;
    hold_idx_next = hold_idx;
    rep_cnt_next  = rep_cnt;
    ram_we        = 1'b0;
    ram_waddr     = walk_idx;
    ram_wdata     = '0;
    ram_raddr     = walk_idx;
    load_wr       = 1'b0;
    fp_clr        = 1'b0;
    rq_push       = 1'b0;
    rq_din        = RES_NOFIRE;
    unique case (state)
      B_IDLE: begin
        if (cmd_valid && space_ok) begin
          cmd_ready = 1'b1;
          unique case (cmd.op)
            OP_TICK: begin
              ram_raddr     = '0;
              walk_idx_next = '0;
              hold_vld_next = 1'b0;
              rep_cnt_next  = '0;
              state_next    = B_WALK;
            end
            OP_DELAY: begin
              ram_raddr  = cmd.idx;
              state_next = B_DELAY;
            end
            OP_LOAD: begin
              ram_we           = 1'b1;
              ram_waddr        = cmd.idx;
              ram_wdata.period = cmd.b;
              ram_wdata.last   = cmd.a;
              ram_wdata.saved  = '0;
              load_wr          = 1'b1;
              rq_push          = 1'b1;
            end
            default: begin
              rq_push = 1'b1;
            end
          endcase
        end
      end
      B_DELAY: begin
        ram_we           = 1'b1;
        ram_waddr        = cur.idx;
        ram_wdata.saved  = (ev.saved == '0) ? ev.period : ev.saved;
        ram_wdata.period = cur.b;
        ram_wdata.last   = cur.restart ? cur.a : ev.last;
        rq_push          = 1'b1;
        state_next       = B_IDLE;
      end
      B_WALK: begin
        if (fire) begin
          ram_we           = 1'b1;
          ram_waddr        = walk_idx;
          ram_wdata.period = (ev.saved != '0) ? ev.saved : ev.period;
          ram_wdata.last   = cur.a;
          ram_wdata.saved  = '0;
          fp_clr           = 1'b1;
          // the newest firing is held back until it is known whether it is the last
          if (rep_cnt < RC_W'(MAX_RESULTS)) begin
            if (hold_vld) begin
              rq_push    = 1'b1;
              rq_din     = '{fired: 1'b1, idx: RES_IDX_W'(hold_idx), last: 1'b0};
            end
            hold_vld_next = 1'b1;
            hold_idx_next = walk_idx;
            rep_cnt_next  = rep_cnt + 1'b1;
          end
        end
        if (walk_idx == TIDX_W'(NUM_TIMERS - 1)) begin
          state_next = B_DONE;
        end else begin
          walk_idx_next = walk_idx + 1'b1;
          ram_raddr     = walk_idx + 1'b1;
        end
      end
      B_DONE: begin
        rq_push = 1'b1;
        if (hold_vld) begin
          rq_din = '{fired: 1'b1, idx: RES_IDX_W'(hold_idx), last: 1'b1};
        end
        state_next = B_IDLE;
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      walk_idx  <= '0;
      hold_vld  <= 1'b0;
      rep_cnt   <= '0;
      ent_valid <= '0;
      active_r  <= '0;
      fpend_r   <= '0;
      rd_ok     <= 1'b0;
    end else begin
      state    <= state_next;
      walk_idx <= walk_idx_next;
      hold_vld <= hold_vld_next;
      rep_cnt  <= rep_cnt_next;
      rd_ok    <= ent_valid[ram_raddr];
      if (ram_we) begin
        ent_valid[ram_waddr] <= 1'b1;
      end
      if (load_wr) begin
        active_r[cmd.idx] <= cmd.act;
        fpend_r[cmd.idx]  <= cmd.first_en;
      end
      if (fp_clr) begin
        fpend_r[walk_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready) begin
      cur <= cmd;
    end
    hold_idx <= hold_idx_next;
  end

  // result queue
  assign rq_pop              = results.valid && results.ready;
  assign results.valid       = (rq_cnt != '0);
  assign results.fired       = rq[rq_rd].fired;
  assign results.fired_index = rq[rq_rd].idx;
  assign results.last_of_run = rq[rq_rd].last;

  always_ff @(posedge clk) begin
    if (rq_push) begin
      rq[rq_wr] <= rq_din;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rq_wr  <= '0;
      rq_rd  <= '0;
      rq_cnt <= '0;
    end else begin
      if (rq_push) begin
        rq_wr <= (rq_wr == RQ_AW'(RESQ_DEPTH - 1)) ? '0 : rq_wr + 1'b1;
      end
      if (rq_pop) begin
        rq_rd <= (rq_rd == RQ_AW'(RESQ_DEPTH - 1)) ? '0 : rq_rd + 1'b1;
      end
      if (rq_push && !rq_pop) begin
        rq_cnt <= rq_cnt + 1'b1;
      end else if (rq_pop && !rq_push) begin
        rq_cnt <= rq_cnt - 1'b1;
      end
    end
  end

endmodule

[rtl/ptb_checker.sv]
// ----------------------------------------------------------------------------
// ptb_checker
// port-level assertions for the timer bank, bound to the top level
// ----------------------------------------------------------------------------
`include "periodic_timer_bank_macros.svh"

module ptb_checker (
  input logic       clk,
  input logic       rst,
  ptb_in_if.sink    items,
  ptb_out_if.source results
);

  // stalled result keeps its payload
  `PTB_ASSERT(a_result_hold, clk, rst, results.valid && !results.ready |=> results.valid && $stable(results.fired) && $stable(results.fired_index) && $stable(results.last_of_run), "result changed while stalled")

  // reset leaves the block ready with no pending result
  `PTB_ASSERT_ALWAYS(a_reset_state, clk, rst |=> items.ready && !results.valid, "bad state after reset")

  // the front works on one item at a time
  `PTB_ASSERT(a_busy_after_accept, clk, rst, items.valid && items.ready |=> !items.ready, "front accepted two items back to back")

  // a non-firing result closes its run and reports index zero
  `PTB_ASSERT(a_nofire_form, clk, rst, results.valid && !results.fired |-> results.last_of_run && results.fired_index == 4'd0, "malformed non-firing result")

endmodule

bind periodic_timer_bank ptb_checker u_ptb_checker (
  .clk     (clk),
  .rst     (rst),
  .items   (items),
  .results (results)
);
